[src/rowl_pkg.sv]
// Package for the relocating object word loader: codes, constants and helpers.
package rowl_pkg;

  localparam int ITEMS_PER_BLOCK = 9;

  localparam logic [17:0] START_OFFSET_RESET = 18'o100;
  localparam logic [35:0] MAGIC_NEW = 36'o124641635413;
  localparam logic [35:0] MAGIC_OLD = 36'o124641635412;
  localparam logic [17:0] HALF_ONES = 18'o777777;
  localparam logic [35:0] WORD_ONES = 36'o777777777777;

  // Loader phases, one-hot.
  typedef enum logic [10:0] {
    PH_MAGIC    = 11'b000_0000_0001,
    PH_VERSION  = 11'b000_0000_0010,
    PH_RELOC    = 11'b000_0000_0100,
    PH_ITEM     = 11'b000_0000_1000,
    PH_ATOMSKIP = 11'b000_0001_0000,
    PH_DEFUNVAL = 11'b000_0010_0000,
    PH_DDTVAL   = 11'b000_0100_0000,
    PH_QLIST    = 11'b000_1000_0000,
    PH_ELIST    = 11'b001_0000_0000,
    PH_HASH     = 11'b010_0000_0000,
    PH_HALT     = 11'b100_0000_0000
  } phase_t;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_MEM       = 3'd0,
    KIND_FUNC_SYM  = 3'd1,
    KIND_DDT_SYM   = 3'd2,
    KIND_END_OK    = 3'd3,
    KIND_BAD_MAGIC = 3'd4,
    KIND_BAD_CODE  = 3'd5
  } kind_t;

  // Per-item relocation codes.
  typedef enum logic [3:0] {
    C_LOAD      = 4'd0,
    C_RELOC     = 4'd1,
    C_CLEAR     = 4'd2,
    C_LOAD_ALT  = 4'd3,
    C_CLEAR_ALT = 4'd4,
    C_QLIST     = 4'd5,
    C_NOP_A     = 4'd6,
    C_PATCH     = 4'd7,
    C_NOP_B     = 4'd8,
    C_BAD       = 4'd9,
    C_ATOM      = 4'd10,
    C_DEFUN     = 4'd11,
    C_ADDR      = 4'd12,
    C_DDT       = 4'd13,
    C_ELIST     = 4'd14,
    C_END       = 4'd15
  } item_code_t;

  // Type field (top three bits) of list words and atom entries.
  localparam logic [2:0] LIST_BAD_A = 3'd5;
  localparam logic [2:0] LIST_BAD_B = 3'd6;
  localparam logic [2:0] LIST_END   = 3'd7;

  localparam logic [2:0] ATOM_RH_LEN_A = 3'd0;
  localparam logic [2:0] ATOM_ONE_A    = 3'd1;
  localparam logic [2:0] ATOM_ONE_B    = 3'd2;
  localparam logic [2:0] ATOM_RH_LEN_B = 3'd3;
  localparam logic [2:0] ATOM_TWO_A    = 3'd4;
  localparam logic [2:0] ATOM_TWO_B    = 3'd5;
  localparam logic [2:0] ATOM_FOUR     = 3'd6;

  // Pick the code for a slot, most significant nibble first.
  function automatic logic [3:0] slot_code(input logic [35:0] rw, input logic [3:0] slot);
    logic [3:0] c;
    case (slot)
      4'd0:    c = rw[35:32];
      4'd1:    c = rw[31:28];
      4'd2:    c = rw[27:24];
      4'd3:    c = rw[23:20];
      4'd4:    c = rw[19:16];
      4'd5:    c = rw[15:12];
      4'd6:    c = rw[11:8];
      4'd7:    c = rw[7:4];
      4'd8:    c = rw[3:0];
      default: c = 4'd0;
    endcase
    return c;
  endfunction

  // Relocate right half (flag bit 0) and/or left half (flag bit 1).
  function automatic logic [35:0] sym_reloc(input logic [35:0] v, input logic [2:0] flags,
                                            input logic [17:0] off);
    logic [17:0] lh;
    logic [17:0] rh;
    lh = v[35:18];
    rh = v[17:0];
    if (flags[0]) rh = rh + off;
    if (flags[1]) lh = lh + off;
    return {lh, rh};
  endfunction

endpackage

[src/relocating_object_word_loader.sv]
// Relocating object word loader: top level, decode, state and result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in      | request   | in_valid / in_stall  | in_word
//  out     | result    | out_valid / out_stall| kind, mem_address, value, symbol_key
//  cfg     | write     | cfg_we               | cfg_data (start_offset)
//
// One word per cycle while results are not stalled: a request sits in the input register,
// is decoded against the loader state by one 18-bit add and a small decode, and its result
// (if any) is registered into the output register as the request leaves the input register.
// Reset (synchronous, rst high) returns to waiting for the magic word, start_offset 64.
// A stalled result holds the output register; the input register keeps taking a
// request while the result register frees up in the same cycle.
module relocating_object_word_loader
  import rowl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [17:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [35:0] in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [17:0] mem_address,
  output logic [35:0] value,
  output logic [31:0] symbol_key
);

  // Configuration register.
  logic [17:0] start_offset;

  // Input register.
  logic        s1_valid;
  logic [35:0] s1_word;

  // Loader state.
  phase_t      phase, phase_next;
  logic [35:0] reloc_word, reloc_word_next;
  logic [3:0]  slot_count, slot_count_next;
  logic [17:0] load_address, load_address_next;
  logic [35:0] last_word, last_word_next;
  logic [17:0] skip_count, skip_count_next;
  logic [31:0] pending_key, pending_key_next;
  logic [2:0]  pending_flags, pending_flags_next;

  // Result of the current request.
  logic        res_valid;
  kind_t       res_kind;
  logic [17:0] res_addr;
  logic [35:0] res_value;
  logic [31:0] res_key;

  logic advance;
  logic in_accept;

  // Advance the input register whenever the result register is free or draining.
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    logic        fin;
    logic        ld;
    logic [35:0] ld_word;
    logic        lw;
    logic        lw_q;
    logic        bad;
    logic [2:0]  wtype;
    logic [17:0] atom_len;
    logic [3:0]  slot_inc;
    item_code_t  code;

    phase_next         = phase;
    reloc_word_next    = reloc_word;
    slot_count_next    = slot_count;
    load_address_next  = load_address;
    last_word_next     = last_word;
    skip_count_next    = skip_count;
    pending_key_next   = pending_key;
    pending_flags_next = pending_flags;

    res_valid = 1'b0;
    res_kind  = KIND_MEM;
    res_addr  = '0;
    res_value = '0;
    res_key   = '0;

    fin      = 1'b0;
    ld       = 1'b0;
    ld_word  = '0;
    lw       = 1'b0;
    lw_q     = 1'b0;
    bad      = 1'b0;
    atom_len = '0;
    wtype    = s1_word[35:33];
    slot_inc = slot_count + 4'd1;
    code     = item_code_t'(slot_code(reloc_word, slot_count));

    if (advance) begin
      unique case (phase)
        PH_MAGIC: begin
          if (s1_word == MAGIC_NEW || s1_word == MAGIC_OLD) begin
            phase_next = PH_VERSION;
          end else begin
            phase_next = PH_HALT;
            res_valid  = 1'b1;
            res_kind   = KIND_BAD_MAGIC;
            res_value  = s1_word;
          end
        end
        PH_VERSION: begin
          load_address_next = start_offset;
          phase_next        = PH_RELOC;
        end
        PH_RELOC: begin
          reloc_word_next = s1_word;
          slot_count_next = '0;
          phase_next      = PH_ITEM;
        end
        PH_ITEM: begin
          case (code) inside
            C_LOAD, C_LOAD_ALT: begin
              ld      = 1'b1;
              ld_word = s1_word;
              fin     = 1'b1;
            end
            C_RELOC: begin
              ld      = 1'b1;
              ld_word = {s1_word[35:18], s1_word[17:0] + start_offset};
              fin     = 1'b1;
            end
            C_CLEAR, C_CLEAR_ALT: begin
              ld      = 1'b1;
              ld_word = {s1_word[35:18], 18'd0};
              fin     = 1'b1;
            end
            C_QLIST: begin
              lw   = 1'b1;
              lw_q = 1'b1;
            end
            C_ELIST: lw = 1'b1;
            C_PATCH: begin
              // Only an all-ones word patches: add offset into the left half.
              if (s1_word == WORD_ONES) begin
                last_word_next = {last_word[35:18] + start_offset, last_word[17:0]};
                res_valid      = 1'b1;
                res_kind       = KIND_MEM;
                res_addr       = load_address - 18'd1;
                res_value      = {last_word[35:18] + start_offset, last_word[17:0]};
              end
              fin = 1'b1;
            end
            C_NOP_A, C_NOP_B: fin = 1'b1;
            C_BAD: bad = 1'b1;
            C_ATOM: begin
              case (wtype) inside
                ATOM_RH_LEN_A, ATOM_RH_LEN_B: atom_len = s1_word[17:0];
                ATOM_ONE_A, ATOM_ONE_B:       atom_len = 18'd1;
                ATOM_TWO_A, ATOM_TWO_B:       atom_len = 18'd2;
                ATOM_FOUR:                    atom_len = 18'd4;
                default:                      bad = 1'b1;
              endcase
              if (!bad) begin
                skip_count_next = atom_len;
                if (atom_len == 18'd0) begin
                  fin = 1'b1;
                end else begin
                  phase_next = PH_ATOMSKIP;
                end
              end
            end
            C_DEFUN: begin
              pending_key_next = {14'd0, s1_word[35:18]};
              phase_next       = PH_DEFUNVAL;
            end
            C_ADDR: begin
              load_address_next = s1_word[17:0] + start_offset;
              fin               = 1'b1;
            end
            C_DDT: begin
              pending_key_next   = s1_word[31:0];
              pending_flags_next = s1_word[35:33];
              if (s1_word[35]) begin
                phase_next = PH_DDTVAL;
              end else begin
                res_valid = 1'b1;
                res_kind  = KIND_DDT_SYM;
                res_value = sym_reloc({18'd0, load_address}, s1_word[35:33], start_offset);
                res_key   = s1_word[31:0];
                fin       = 1'b1;
              end
            end
            C_END: begin
              phase_next = PH_HALT;
              res_valid  = 1'b1;
              res_kind   = (s1_word == MAGIC_NEW || s1_word == MAGIC_OLD) ? KIND_END_OK
                                                                          : KIND_BAD_MAGIC;
              res_value  = s1_word;
            end
            default: fin = 1'b1;
          endcase
        end
        PH_ATOMSKIP: begin
          skip_count_next = skip_count - 18'd1;
          if (skip_count == 18'd1) fin = 1'b1;
        end
        PH_DEFUNVAL: begin
          res_valid = 1'b1;
          res_kind  = KIND_FUNC_SYM;
          res_value = {18'd0, s1_word[17:0] + start_offset};
          res_key   = pending_key;
          fin       = 1'b1;
        end
        PH_DDTVAL: begin
          res_valid = 1'b1;
          res_kind  = KIND_DDT_SYM;
          res_value = sym_reloc(s1_word, pending_flags, start_offset);
          res_key   = pending_key;
          fin       = 1'b1;
        end
        PH_QLIST: begin
          lw   = 1'b1;
          lw_q = 1'b1;
        end
        PH_ELIST: lw = 1'b1;
        PH_HASH:  fin = 1'b1;
        default: ;
      endcase

      // List words: stay in the list until its terminator.
      if (lw) begin
        if (wtype == LIST_BAD_A || wtype == LIST_BAD_B) begin
          bad = 1'b1;
        end else if (wtype != LIST_END) begin
          phase_next = lw_q ? PH_QLIST : PH_ELIST;
        end else if (lw_q) begin
          if (s1_word[35:18] == HALF_ONES) begin
            ld      = 1'b1;
            ld_word = s1_word;
          end
          phase_next = PH_HASH;
        end else begin
          fin = 1'b1;
        end
      end

      if (ld) begin
        last_word_next    = ld_word;
        load_address_next = load_address + 18'd1;
        res_valid         = 1'b1;
        res_kind          = KIND_MEM;
        res_addr          = load_address;
        res_value         = ld_word;
      end

      if (bad) begin
        phase_next = PH_HALT;
        res_valid  = 1'b1;
        res_kind   = KIND_BAD_CODE;
        res_addr   = '0;
        res_value  = s1_word;
      end

      // Step to the next slot, or back to a relocation word after the last one.
      if (fin) begin
        slot_count_next = slot_inc;
        phase_next = (slot_inc >= 4'(ITEMS_PER_BLOCK)) ? PH_RELOC : PH_ITEM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset  <= START_OFFSET_RESET;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      phase         <= PH_MAGIC;
      reloc_word    <= '0;
      slot_count    <= '0;
      load_address  <= START_OFFSET_RESET;
      last_word     <= '0;
      skip_count    <= '0;
      pending_key   <= '0;
      pending_flags <= '0;
    end else begin
      if (cfg_we) start_offset <= cfg_data;

      // Hold the input register until its request advances.
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      // Drop a taken result unless a new one replaces it.
      if (advance) begin
        out_valid <= res_valid;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      phase         <= phase_next;
      reloc_word    <= reloc_word_next;
      slot_count    <= slot_count_next;
      load_address  <= load_address_next;
      last_word     <= last_word_next;
      skip_count    <= skip_count_next;
      pending_key   <= pending_key_next;
      pending_flags <= pending_flags_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) s1_word <= in_word;
    if (advance && res_valid) begin
      kind        <= res_kind;
      mem_address <= res_addr;
      value       <= res_value;
      symbol_key  <= res_key;
    end
  end

  // Once halted, no further result appears.
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HALT && !out_valid) |=> !out_valid)
    else $error("result produced after halt");

  // A slot index past the block never reaches item decode.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ITEM) |-> (slot_count < 4'(ITEMS_PER_BLOCK)))
    else $error("slot count out of range in item phase");

  // Only memory writes carry an address.
  a_addr_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_MEM) |-> (mem_address == 18'd0))
    else $error("address on a non-write result");

  // A stalled request is held in the input register, never lost.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> (s1_valid && $stable(s1_word)))
    else $error("stalled request not held");

endmodule

[test/relocating_object_word_loader_tb.sv]
// Self-checking testbench for the relocating object word loader.
module relocating_object_word_loader_tb
  import rowl_pkg::*;
();

  // Cycles with no transfer on either channel before the run is declared hung.
  localparam int IDLE_LIMIT = 2000;
  // Extra cycles to let the two-stage pipe empty once nothing is expected.
  localparam int SETTLE_CYCLES = 8;
  // Receiver hold-off: start once this many results arrived, hold this long.
  localparam int HOLD_AFTER = 40;
  localparam int HOLD_CYCLES = 80;

  // Atom entry type that the loader rejects.
  localparam logic [2:0] ATOM_BAD = 3'd7;
  // Debugger symbol flags: both halves relocated, or value in the next word.
  localparam logic [2:0] DDT_BOTH_HALVES = 3'b011;
  localparam logic [2:0] DDT_WITH_VALUE = 3'b111;

  typedef struct packed {
    kind_t       kind;
    logic [17:0] mem_address;
    logic [35:0] value;
    logic [31:0] symbol_key;
  } load_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [17:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [35:0] in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [17:0] mem_address;
  logic [35:0] value;
  logic [31:0] symbol_key;

  relocating_object_word_loader u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .mem_address (mem_address),
    .value       (value),
    .symbol_key  (symbol_key)
  );

  always #5 clk = ~clk;

  // Stimulus and scoreboard storage.
  logic [35:0]  object_words[$];
  load_result_t pending_results[$];
  int unsigned  words_queued;

  // Idle mix: 0 sender 28 / receiver 51, 1 the other way round, 2 no idling.
  int unsigned  idle_mode;
  int unsigned  send_idle_pct[3] = '{28, 51, 0};
  int unsigned  recv_idle_pct[3] = '{51, 28, 0};

  // Written at the rising edge, read at the falling edge.
  bit           word_taken;
  int unsigned  requests_seen;
  int unsigned  results_seen;
  int unsigned  mem_writes;
  int unsigned  symbols_seen;
  int unsigned  mismatches;
  kind_t        last_kind;
  int unsigned  idle_cycles;
  int unsigned  hold_left;
  bit           hold_done;

  // Loader state as the scoreboard sees it.
  phase_t      ld_phase;
  logic [17:0] ld_offset;
  logic [35:0] ld_reloc;
  logic [3:0]  ld_slot;
  logic [17:0] ld_addr;
  logic [35:0] ld_last;
  logic [17:0] ld_skip;
  logic [31:0] ld_key;
  logic [2:0]  ld_flags;

  // ---------------------------------------------------------------------------
  // Load prediction
  // ---------------------------------------------------------------------------

  function automatic load_result_t make_result(input kind_t k, input logic [17:0] a,
                                               input logic [35:0] v, input logic [31:0] key);
    load_result_t r;
    r.kind = k;
    r.mem_address = a;
    r.value = v;
    r.symbol_key = key;
    return r;
  endfunction

  // Advance to the next slot of the block; after the ninth, expect a relocation word.
  function automatic void next_slot();
    ld_slot = ld_slot + 4'd1;
    ld_phase = (ld_slot >= ITEMS_PER_BLOCK) ? PH_RELOC : PH_ITEM;
  endfunction

  // Store a word at the load address and bump the address (wraps at 18 bits).
  function automatic load_result_t load_next(input logic [35:0] w);
    load_result_t r;
    ld_last = w;
    r = make_result(KIND_MEM, ld_addr, w, '0);
    ld_addr = ld_addr + 18'd1;
    return r;
  endfunction

  // Add the offset to the right half (flag bit 0) and/or the left half (flag bit 1).
  function automatic logic [35:0] shift_halves(input logic [35:0] v, input logic [2:0] flags);
    logic [17:0] left_half;
    logic [17:0] right_half;
    left_half = v[35:18];
    right_half = v[17:0];
    if (flags[0]) right_half = right_half + ld_offset;
    if (flags[1]) left_half = left_half + ld_offset;
    return {left_half, right_half};
  endfunction

  function automatic bit halt_on_bad(input logic [35:0] w, output load_result_t r);
    ld_phase = PH_HALT;
    r = make_result(KIND_BAD_CODE, '0, w, '0);
    return 1'b1;
  endfunction

  // One word of a quoted or evaluated list; the type in the top bits decides.
  function automatic bit list_step(input logic [35:0] w, input bit quoted,
                                   output load_result_t r);
    r = '0;
    if (w[35:33] == LIST_BAD_A || w[35:33] == LIST_BAD_B) return halt_on_bad(w, r);
    if (w[35:33] != LIST_END) begin
      ld_phase = quoted ? PH_QLIST : PH_ELIST;
      return 1'b0;
    end
    if (!quoted) begin
      next_slot();
      return 1'b0;
    end
    // Quoted terminator: load it only when its left half is all ones, then skip the hash key.
    ld_phase = PH_HASH;
    if (w[35:18] == HALF_ONES) begin
      r = load_next(w);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit atom_step(input logic [35:0] w, output load_result_t r);
    logic [17:0] len;
    r = '0;
    case (w[35:33])
      ATOM_RH_LEN_A, ATOM_RH_LEN_B: len = w[17:0];
      ATOM_ONE_A, ATOM_ONE_B:       len = 18'd1;
      ATOM_TWO_A, ATOM_TWO_B:       len = 18'd2;
      ATOM_FOUR:                    len = 18'd4;
      default:                      return halt_on_bad(w, r);
    endcase
    ld_skip = len;
    // An empty entry finishes the item on the spot.
    if (len == 18'd0) next_slot();
    else ld_phase = PH_ATOMSKIP;
    return 1'b0;
  endfunction

  // A word governed by the current slot's code of the relocation word.
  function automatic bit item_step(input logic [35:0] w, output load_result_t r);
    item_code_t code;
    bit         hit;
    code = item_code_t'(ld_reloc[35 - 4 * int'(ld_slot) -: 4]);
    hit = 1'b0;
    r = '0;
    case (code)
      C_LOAD, C_LOAD_ALT: begin
        r = load_next(w);
        hit = 1'b1;
      end
      C_RELOC: begin
        r = load_next({w[35:18], w[17:0] + ld_offset});
        hit = 1'b1;
      end
      C_CLEAR, C_CLEAR_ALT: begin
        r = load_next({w[35:18], 18'd0});
        hit = 1'b1;
      end
      C_QLIST: return list_step(w, 1'b1, r);
      C_ELIST: return list_step(w, 1'b0, r);
      C_PATCH: begin
        // Patch the last loaded word, written back one below the current address.
        if (w == WORD_ONES) begin
          ld_last[35:18] = ld_last[35:18] + ld_offset;
          r = make_result(KIND_MEM, ld_addr - 18'd1, ld_last, '0);
          hit = 1'b1;
        end
      end
      C_BAD:  return halt_on_bad(w, r);
      C_ATOM: return atom_step(w, r);
      C_DEFUN: begin
        ld_key = {14'd0, w[35:18]};
        ld_phase = PH_DEFUNVAL;
        return 1'b0;
      end
      C_ADDR: ld_addr = w[17:0] + ld_offset;
      C_DDT: begin
        ld_key = w[31:0];
        ld_flags = w[35:33];
        if (ld_flags[2]) begin
          ld_phase = PH_DDTVAL;
          return 1'b0;
        end
        r = make_result(KIND_DDT_SYM, '0, shift_halves({18'd0, ld_addr}, ld_flags), ld_key);
        hit = 1'b1;
      end
      C_END: begin
        ld_phase = PH_HALT;
        r = make_result((w == MAGIC_NEW || w == MAGIC_OLD) ? KIND_END_OK : KIND_BAD_MAGIC,
                        '0, w, '0);
        return 1'b1;
      end
      default: ;
    endcase
    next_slot();
    return hit;
  endfunction

  // Work out the result (if any) that one accepted word causes.
  function automatic bit decode_word(input logic [35:0] w, output load_result_t r);
    bit hit;
    hit = 1'b0;
    r = '0;
    case (ld_phase)
      PH_MAGIC: begin
        if (w == MAGIC_NEW || w == MAGIC_OLD) begin
          ld_phase = PH_VERSION;
        end else begin
          ld_phase = PH_HALT;
          r = make_result(KIND_BAD_MAGIC, '0, w, '0);
          hit = 1'b1;
        end
      end
      PH_VERSION: begin
        // The load address is set to the offset here.
        ld_addr = ld_offset;
        ld_phase = PH_RELOC;
      end
      PH_RELOC: begin
        ld_reloc = w;
        ld_slot = '0;
        ld_phase = PH_ITEM;
      end
      PH_ITEM: hit = item_step(w, r);
      PH_ATOMSKIP: begin
        ld_skip = ld_skip - 18'd1;
        if (ld_skip == 18'd0) next_slot();
      end
      PH_DEFUNVAL: begin
        next_slot();
        r = make_result(KIND_FUNC_SYM, '0, {18'd0, w[17:0] + ld_offset}, ld_key);
        hit = 1'b1;
      end
      PH_DDTVAL: begin
        next_slot();
        r = make_result(KIND_DDT_SYM, '0, shift_halves(w, ld_flags), ld_key);
        hit = 1'b1;
      end
      PH_QLIST: hit = list_step(w, 1'b1, r);
      PH_ELIST: hit = list_step(w, 1'b0, r);
      PH_HASH:  next_slot();
      default: ;
    endcase
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Stream generation: well-formed blocks with random content
  // ---------------------------------------------------------------------------

  function automatic logic [35:0] any_word();
    logic [35:0] w;
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = WORD_ONES;
      default: w = {4'($urandom_range(0, 15)), 32'($urandom())};
    endcase
    return w;
  endfunction

  function automatic logic [35:0] typed_word(input logic [2:0] t);
    logic [35:0] w;
    w = any_word();
    w[35:33] = t;
    return w;
  endfunction

  function automatic void push_word(input logic [35:0] w);
    object_words.push_back(w);
    words_queued++;
  endfunction

  // Zero to three body words, then the terminator; a quoted list adds a hash key.
  function automatic void gen_list(input bit quoted);
    logic [35:0] w;
    repeat ($urandom_range(0, 3)) push_word(typed_word(3'($urandom_range(0, 4))));
    w = typed_word(LIST_END);
    if ($urandom_range(0, 1) != 0) w[35:18] = HALF_ONES;
    push_word(w);
    if (quoted) push_word(any_word());
  endfunction

  function automatic void gen_atom();
    logic [35:0] w;
    int          n;
    w = typed_word(3'($urandom_range(0, 6)));
    case (w[35:33])
      ATOM_RH_LEN_A, ATOM_RH_LEN_B: begin
        w[17:0] = 18'($urandom_range(0, 3));
        n = int'(w[17:0]);
      end
      ATOM_ONE_A, ATOM_ONE_B: n = 1;
      ATOM_TWO_A, ATOM_TWO_B: n = 2;
      default:                n = 4;
    endcase
    push_word(w);
    repeat (n) push_word(any_word());
  endfunction

  function automatic void gen_item(input item_code_t code);
    logic [35:0] w;
    case (code)
      C_PATCH: push_word(($urandom_range(0, 2) != 0) ? WORD_ONES : any_word());
      C_QLIST: gen_list(1'b1);
      C_ELIST: gen_list(1'b0);
      C_ATOM:  gen_atom();
      C_DEFUN: begin
        push_word(any_word());
        push_word(any_word());
      end
      C_DDT: begin
        w = any_word();
        push_word(w);
        if (w[35]) push_word(any_word());
      end
      default: push_word(any_word());
    endcase
  endfunction

  // Relocation word with nine codes that never stop the loader, then its items.
  function automatic void gen_block();
    item_code_t  codes[ITEMS_PER_BLOCK];
    logic [35:0] rw;
    rw = '0;
    foreach (codes[i]) begin
      codes[i] = item_code_t'($urandom_range(0, 13));
      if (codes[i] >= C_BAD) codes[i] = item_code_t'(codes[i] + 1);
      rw[35 - 4 * i -: 4] = codes[i];
    end
    push_word(rw);
    foreach (codes[i]) gen_item(codes[i]);
  endfunction

  // Close the stream one of the ways that halt the loader, then trail a few ignored words.
  function automatic void gen_stream_end();
    logic [35:0] rw;
    logic [35:0] w;
    rw = any_word();
    case ($urandom_range(0, 4))
      0: begin
        rw[35:32] = C_END;
        w = ($urandom_range(0, 1) != 0) ? MAGIC_NEW : MAGIC_OLD;
      end
      1: begin
        rw[35:32] = C_END;
        w = any_word();
      end
      2: begin
        rw[35:32] = C_BAD;
        w = any_word();
      end
      3: begin
        rw[35:32] = ($urandom_range(0, 1) != 0) ? C_QLIST : C_ELIST;
        w = typed_word(($urandom_range(0, 1) != 0) ? LIST_BAD_A : LIST_BAD_B);
      end
      default: begin
        rw[35:32] = C_ATOM;
        w = typed_word(ATOM_BAD);
      end
    endcase
    push_word(rw);
    push_word(w);
    repeat (5) object_words.push_back(any_word());
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  // Hold until every word is taken and every result is in, then let the pipe settle.
  task automatic wait_drained();
    do @(posedge clk);
    while (object_words.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_offset(input logic [17:0] off);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= off;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [35:0] w;
    idle_mode = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Magic word alone, then move the offset before the version word arrives:
    // the load address must start at the top of memory and wrap on the next load.
    push_word(($urandom_range(0, 1) != 0) ? MAGIC_NEW : MAGIC_OLD);
    wait_drained();
    write_offset(HALF_ONES);
    push_word(any_word());

    // Plain, relocated and cleared loads, a patch, a non-matching patch, two no-ops.
    push_word({C_LOAD, C_RELOC, C_CLEAR, C_LOAD_ALT, C_CLEAR_ALT,
               C_PATCH, C_NOP_A, C_PATCH, C_NOP_B});
    push_word(WORD_ONES);
    push_word({18'o123456, HALF_ONES});
    push_word(WORD_ONES);
    push_word('0);
    push_word(any_word());
    push_word(WORD_ONES);
    push_word(any_word());
    push_word(WORD_ONES - 36'd1);
    push_word(any_word());

    // Address move, both symbol kinds, both lists, empty and long atom entries,
    // and a patch that lands on the moved address.
    push_word({C_ADDR, C_DEFUN, C_DDT, C_DDT, C_QLIST, C_ELIST, C_ATOM, C_ATOM, C_PATCH});
    w = any_word();
    w[17:0] = HALF_ONES;
    push_word(w);
    push_word(WORD_ONES);
    push_word(WORD_ONES);
    push_word(typed_word(DDT_BOTH_HALVES));
    push_word(typed_word(DDT_WITH_VALUE));
    push_word(WORD_ONES);
    push_word(typed_word(3'd0));
    push_word({HALF_ONES, 18'($urandom())});
    push_word(any_word());
    push_word(typed_word(LIST_END));
    w = typed_word(ATOM_RH_LEN_A);
    w[17:0] = '0;
    push_word(w);
    push_word(typed_word(ATOM_FOUR));
    repeat (4) push_word(any_word());
    push_word(WORD_ONES);

    // Random blocks under three offsets and three idle mixes.
    while (words_queued < 230) gen_block();
    wait_drained();

    idle_mode = 1;
    write_offset('0);
    while (words_queued < 450) gen_block();
    wait_drained();

    idle_mode = 2;
    write_offset(18'($urandom()));
    while (words_queued < 640) gen_block();
    gen_stream_end();
    wait_drained();

    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end
    $display("covered %0d words and %0d results: %0d memory writes, %0d symbols",
             requests_seen, results_seen, mem_writes, symbols_seen);
    $display("offsets top, zero and random; stream stopped by %s", last_kind.name());
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: one request at a time from the word queue, changed at the falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin : word_driver
    bit offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // Keep a stalled request up; otherwise maybe idle, else present the next word.
      offer = in_valid && !word_taken;
      if (!offer && object_words.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct[idle_mode]) begin
        in_word <= object_words.pop_front();
        offer = 1'b1;
      end
      in_valid <= offer;
    end
  end

  // Receiver stall: random per idle mix, plus one long hold-off to back up the pipe.
  always @(negedge clk) begin : result_stall
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct[idle_mode]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted request, compare each accepted result
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string field, input logic [35:0] want,
                                      input logic [35:0] got);
    if (got !== want) begin
      $error("%s: expected 'o%0o, got 'o%0o", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    load_result_t pred;
    load_result_t want;
    if (rst) begin
      word_taken = 1'b0;
      ld_phase = PH_MAGIC;
      ld_offset = START_OFFSET_RESET;
      ld_reloc = '0;
      ld_slot = '0;
      ld_addr = START_OFFSET_RESET;
      ld_last = '0;
      ld_skip = '0;
      ld_key = '0;
      ld_flags = '0;
    end else begin
      if (cfg_we) ld_offset = cfg_data;
      word_taken = in_valid && !in_stall;
      if (word_taken) begin
        requests_seen++;
        if (decode_word(in_word, pred)) pending_results.push_back(pred);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        last_kind = kind_t'(kind);
        if (kind == KIND_MEM) mem_writes++;
        if (kind == KIND_FUNC_SYM || kind == KIND_DDT_SYM) symbols_seen++;
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: kind %0d value 'o%0o", kind, value);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, kind);
          check_field("mem_address", want.mem_address, mem_address);
          check_field("value", want.value, value);
          check_field("symbol_key", want.symbol_key, symbol_key);
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule
